// ----- hdl/ntc_pkg.sv -----
// ----------------------------------------------------------------------------
// ntc_pkg
// types, template tables and the hit classifier shared by the hit counter
// ----------------------------------------------------------------------------
package ntc_pkg;

	localparam int TMPL_START = 12;
	localparam int TMPL_BINS  = 21;
	localparam int CNT_W      = 7;
	localparam int BIG_W      = 2;
	localparam int RQ_DEPTH   = 4;
	localparam int RQ_PTR_W   = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W   = $clog2(RQ_DEPTH + 1);

	localparam logic [6:0] TMPL_MEAN [TMPL_BINS] = '{
		7'd0, 7'd0, 7'd0, 7'd50, 7'd67, 7'd65, 7'd43, 7'd40, 7'd25, 7'd0, 7'd0,
		7'd50, 7'd67, 7'd65, 7'd45, 7'd42, 7'd28, 7'd26, 7'd0, 7'd0, 7'd0};
	localparam logic [4:0] TMPL_SPREAD [TMPL_BINS] = '{
		5'd15, 5'd20, 5'd25, 5'd23, 5'd23, 5'd23, 5'd18, 5'd21, 5'd15, 5'd20, 5'd25,
		5'd23, 5'd23, 5'd23, 5'd18, 5'd20, 5'd15, 5'd14, 5'd0, 5'd0, 5'd0};
	// lower limit present in this bin (all present limits are zero)
	localparam logic [TMPL_BINS-1:0] TMPL_FLOOR_VLD = 21'b1_1110_0000_0001_0000_0000;
	localparam logic [6:0] TMPL_FLOOR [TMPL_BINS] = '{default: 7'd0};

	typedef enum logic [1:0] {
		CLS_OFF = 2'd0,
		CLS_ON  = 2'd1,
		CLS_FAR = 2'd2
	} cls_t;

	typedef struct packed {
		logic far0;
		logic on0;
		logic onm;
		logic onp;
	} match_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt_zero;
		logic [CNT_W-1:0] cnt_minus;
		logic [CNT_W-1:0] cnt_plus;
		logic [BIG_W-1:0] big;
		logic [CNT_W-1:0] hits;
	} state_t;

	typedef struct packed {
		logic             many_big;
		logic [CNT_W-1:0] noise_count;
	} result_t;

	function automatic cls_t classify(input logic signed [9:0] tt, input logic [9:0] amp);
		logic signed [9:0]  b;
		logic signed [12:0] a;
		logic signed [12:0] m;
		logic signed [12:0] e;
		logic signed [12:0] d;
		logic               fv;
		cls_t               r;
		b = tt - 10'sd12;
		a = signed'({3'b000, amp});
		m = '0;
		e = '0;
		d = '0;
		fv = 1'b0;
		if (b < 10'sd0 || b > 10'sd20) begin
			r = CLS_OFF;
		end else begin
			m = signed'({6'd0, TMPL_MEAN[b[4:0]]});
			e = signed'({8'd0, TMPL_SPREAD[b[4:0]]});
			d = signed'({6'd0, TMPL_FLOOR[b[4:0]]});
			fv = TMPL_FLOOR_VLD[b[4:0]];
			if (a > m + (e <<< 1))
				r = CLS_FAR;
			// a < m - 1.5e, doubled on both sides
			else if (fv && (a <<< 1) < (m <<< 1) - ((e <<< 1) + e))
				r = CLS_FAR;
			else if (a > m + e)
				r = CLS_OFF;
			else if (fv ? (a < d) : (a < m - e))
				r = CLS_OFF;
			else
				r = CLS_ON;
		end
		return r;
	endfunction

endpackage

// ----- hdl/noise_template_hit_counter.sv -----
// ----------------------------------------------------------------------------
// noise_template_hit_counter
// scores one pad's hit list against a fixed 21-bin noise template
//
// each request is one hit (time bin, amplitude) of a pad's list; tlast closes
// the list and produces one result: the largest on-curve count over time
// shifts -1, 0 and +1, and a flag set when more than one hit lay far off the
// curve. tuser low marks an empty item that counts nothing. hits beyond the
// first MAX_HITS of a list are ignored, but their tlast still ends the list.
// the block takes one request per clock while s_tready is high; the running
// counts live in a one-entry state ram that is read on accept and written
// back in the cycle after, with the write forwarded to an item that follows
// in the next cycle. a result passes from stage 1 into a four-entry queue,
// where it waits for the master side; s_tready drops only when that queue,
// counting a result still in the pipeline, holds three results.
// ----------------------------------------------------------------------------
module noise_template_hit_counter #(
	parameter int MAX_HITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // hit_time[7:0], hit_amplitude[17:8], zero fill
	input  logic        s_tuser,   // hit_present
	input  logic        s_tlast,   // last_hit
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // noise_count[6:0], many_big[7]
);
	import ntc_pkg::*;

	localparam logic [CNT_W-1:0] HIT_LIMIT = CNT_W'(MAX_HITS);

	// input side
	logic   accept;
	match_t match;

	// stage 1 of the pipeline
	logic   vld_s1;
	logic   last_s1;
	logic   present_s1;
	match_t match_s1;

	// state ram and forwarding
	state_t               rd_state;
	state_t               cur_state;
	state_t               nxt_state;
	state_t               wr_state;
	state_t               fwd_q;
	logic                 fwd_vld_q;
	logic                 written_q;
	logic                 take;

	// result path
	result_t              result;
	result_t              out_data;
	logic [RQ_CNT_W-1:0]  level;
	logic [CNT_W-1:0]     best_zm;

	assign accept = s_tvalid && s_tready;

	// room for this request's result plus one still in flight
	assign s_tready = ({1'b0, level} + {{RQ_CNT_W{1'b0}}, vld_s1 && last_s1})
		<= (RQ_CNT_W+1)'(RQ_DEPTH - 2);

	ntc_match u_match (
		.hit_time      (s_tdata[7:0]),
		.hit_amplitude (s_tdata[17:8]),
		.match         (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1    <= s_tlast;
			present_s1 <= s_tuser;
			match_s1   <= match;
		end
	end

	ntc_ram #(
		.WIDTH ($bits(state_t)),
		.DEPTH (1)
	) u_state_ram (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (1'b0),
		.wdata (wr_state),
		.raddr (1'b0),
		.rdata (rd_state)
	);

	// previous cycle's write wins over the stale read; never-written reads as zero
	always_comb begin
		priority if (fwd_vld_q)
			cur_state = fwd_q;
		else if (written_q)
			cur_state = rd_state;
		else
			cur_state = '0;
	end

	assign take = present_s1 && (cur_state.hits < HIT_LIMIT);

	always_comb begin
		nxt_state = cur_state;
		if (take) begin
			nxt_state.hits = cur_state.hits + CNT_W'(1);
			if (match_s1.on0)
				nxt_state.cnt_zero = cur_state.cnt_zero + CNT_W'(1);
			if (match_s1.onm)
				nxt_state.cnt_minus = cur_state.cnt_minus + CNT_W'(1);
			if (match_s1.onp)
				nxt_state.cnt_plus = cur_state.cnt_plus + CNT_W'(1);
			if (match_s1.far0 && cur_state.big != BIG_W'(2))
				nxt_state.big = cur_state.big + BIG_W'(1);
		end
	end

	// list end clears all counts
	assign wr_state = last_s1 ? '0 : nxt_state;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
			written_q <= 1'b0;
		end else begin
			fwd_vld_q <= vld_s1;
			if (vld_s1)
				written_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1)
			fwd_q <= wr_state;
	end

	// best of the three shifted counts
	assign best_zm = (nxt_state.cnt_minus > nxt_state.cnt_zero) ?
		nxt_state.cnt_minus : nxt_state.cnt_zero;
	assign result.noise_count = (nxt_state.cnt_plus > best_zm) ? nxt_state.cnt_plus : best_zm;
	assign result.many_big    = (nxt_state.big > BIG_W'(1));

	ntc_result_q u_result_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (vld_s1 && last_s1),
		.push_data (result),
		.level     (level),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_data    (out_data)
	);

	assign m_tdata = {out_data.many_big, out_data.noise_count};

endmodule

// ----- hdl/ntc_ram.sv -----
// ----------------------------------------------------------------------------
// ntc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module ntc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/ntc_match.sv -----
// ----------------------------------------------------------------------------
// ntc_match
// template match of one hit at time shifts 0, -1 and +1
// ----------------------------------------------------------------------------
module ntc_match (
	input  logic [7:0]      hit_time,
	input  logic [9:0]      hit_amplitude,
	output ntc_pkg::match_t match
);
	import ntc_pkg::*;

	logic signed [9:0] t_zero;
	logic signed [9:0] t_minus;
	logic signed [9:0] t_plus;
	cls_t              c_zero;

	assign t_zero  = signed'({2'b00, hit_time});
	assign t_minus = t_zero - 10'sd1;
	assign t_plus  = t_zero + 10'sd1;

	assign c_zero = classify(t_zero, hit_amplitude);

	assign match.far0 = (c_zero == CLS_FAR);
	assign match.on0  = (c_zero == CLS_ON);
	assign match.onm  = (classify(t_minus, hit_amplitude) == CLS_ON);
	assign match.onp  = (classify(t_plus, hit_amplitude) == CLS_ON);

endmodule

// ----- hdl/ntc_result_q.sv -----
// ----------------------------------------------------------------------------
// ntc_result_q
// small result queue that decouples the output side from the pipeline
// ----------------------------------------------------------------------------
module ntc_result_q (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  ntc_pkg::result_t                  push_data,
	output logic [ntc_pkg::RQ_CNT_W-1:0]      level,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output ntc_pkg::result_t                  m_data
);
	import ntc_pkg::*;

	result_t               slot_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0]   wr_ptr_q;
	logic [RQ_PTR_W-1:0]   rd_ptr_q;
	logic [RQ_CNT_W-1:0]   cnt_q;
	logic                  pop;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != '0);
	assign m_data   = slot_q[rd_ptr_q];
	assign level    = cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + RQ_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + RQ_PTR_W'(1);
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + RQ_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - RQ_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
